### hw/rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants, types and the month length table for the epoch seconds
// to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int SECONDS_BITS = 36;
	localparam int DIGIT_W      = 12;
	localparam int DIGITS       = (SECONDS_BITS + DIGIT_W - 1) / DIGIT_W;
	localparam int DIV_W        = DIGITS * DIGIT_W;
	localparam int CNT_W        = $clog2(DIGITS);
	localparam int REM_W        = 6;
	localparam int PART_W       = REM_W + DIGIT_W;
	localparam int RECIP_W      = 20;
	localparam int PROD_W       = PART_W + RECIP_W;
	localparam int RECIP_SHIFT  = 24;
	localparam int DAYS_W       = SECONDS_BITS - 16;
	localparam int YEAR_W       = 13;

	localparam logic [5:0]         SEC_PER_MIN   = 6'd60;
	localparam logic [5:0]         HOURS_PER_DAY = 6'd24;
	localparam logic [RECIP_W-1:0] RECIP_60      = 20'd279621;
	localparam logic [RECIP_W-1:0] RECIP_24      = 20'd699051;
	localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = YEAR_W'(1970);
	localparam logic [1:0]         EPOCH_MOD4    = 2'd2;
	localparam logic [6:0]         EPOCH_MOD100  = 7'd70;
	localparam logic [8:0]         EPOCH_MOD400  = 9'd370;
	localparam logic [8:0]         DAYS_COMMON   = 9'd365;
	localparam logic [8:0]         DAYS_LEAP     = 9'd366;

	localparam logic [1:0] PH_SEC  = 2'd0;
	localparam logic [1:0] PH_MIN  = 2'd1;
	localparam logic [1:0] PH_HOUR = 2'd2;

	typedef struct packed {
		logic       load;
		logic       div_step;
		logic       div_end;
		logic [1:0] div_phase;
		logic       year_step;
		logic       month_step;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic year_fits;
		logic month_fits;
	} status_t;

	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			4'd11:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### hw/rtl/esc_datapath.sv
// ----------------------------------------------------------------------------
// esc_datapath
// Divider by 60 and 24 that takes twelve bits of the count per cycle through
// a reciprocal multiplication, year and month reduction of the day count with
// running leap counters, and the result register.
// ----------------------------------------------------------------------------
module esc_datapath (
	input  logic                           clk,
	input  esc_pkg::cmd_t                  cmd,
	output esc_pkg::status_t               status,
	input  logic [esc_pkg::SECONDS_BITS-1:0] epoch_seconds,
	output logic [5:0]                     sec_of_minute,
	output logic [5:0]                     min_of_hour,
	output logic [4:0]                     hour_of_day,
	output logic [4:0]                     day_of_month,
	output logic [3:0]                     month_of_year,
	output logic [12:0]                    calendar_year
);

	logic [esc_pkg::DIV_W-1:0]        quo_q;
	logic [5:0]                       rem_q;
	logic [5:0]                       sec_q;
	logic [5:0]                       min_q;
	logic [4:0]                       hour_q;
	logic [esc_pkg::DAYS_W-1:0]       days_q;
	logic [esc_pkg::YEAR_W-1:0]       year_q;
	logic [1:0]                       mod4_q;
	logic [6:0]                       mod100_q;
	logic [8:0]                       mod400_q;
	logic [3:0]                       month_q;

	logic [5:0]                   divisor;
	logic [esc_pkg::RECIP_W-1:0]  recip;
	logic [esc_pkg::PART_W-1:0]   part;
	logic [esc_pkg::PROD_W-1:0]   prod;
	logic [esc_pkg::DIGIT_W-1:0]  qdig;
	logic [5:0]                   rem_next;
	logic                         leap;
	logic [8:0]                   ylen;
	logic [4:0]                   mlen;

	assign divisor  = (cmd.div_phase == esc_pkg::PH_HOUR) ? esc_pkg::HOURS_PER_DAY
		: esc_pkg::SEC_PER_MIN;
	assign recip    = (cmd.div_phase == esc_pkg::PH_HOUR) ? esc_pkg::RECIP_24
		: esc_pkg::RECIP_60;
	assign part     = {rem_q, quo_q[esc_pkg::DIV_W-1 -: esc_pkg::DIGIT_W]};
	assign prod     = esc_pkg::PROD_W'(part) * esc_pkg::PROD_W'(recip);
	assign qdig     = prod[esc_pkg::RECIP_SHIFT +: esc_pkg::DIGIT_W];
	assign rem_next = 6'(part - esc_pkg::PART_W'(qdig) * esc_pkg::PART_W'(divisor));
	assign leap     = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
	assign ylen     = leap ? esc_pkg::DAYS_LEAP : esc_pkg::DAYS_COMMON;
	assign mlen     = esc_pkg::month_days(month_q, leap);

	assign status.year_fits  = days_q < esc_pkg::DAYS_W'(ylen);
	assign status.month_fits = days_q < esc_pkg::DAYS_W'(mlen);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q <= esc_pkg::DIV_W'(epoch_seconds);
			rem_q <= 6'd0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[esc_pkg::DIV_W-esc_pkg::DIGIT_W-1:0], qdig};
			rem_q <= rem_next;
		end else if (cmd.div_end) begin
			rem_q <= 6'd0;
		end

		if (cmd.div_end) begin
			case (cmd.div_phase)
				esc_pkg::PH_SEC:  sec_q  <= rem_q;
				esc_pkg::PH_MIN:  min_q  <= rem_q;
				esc_pkg::PH_HOUR: begin
					hour_q   <= rem_q[4:0];
					days_q   <= quo_q[esc_pkg::DAYS_W-1:0];
					year_q   <= esc_pkg::EPOCH_YEAR;
					mod4_q   <= esc_pkg::EPOCH_MOD4;
					mod100_q <= esc_pkg::EPOCH_MOD100;
					mod400_q <= esc_pkg::EPOCH_MOD400;
					month_q  <= 4'd0;
				end
				default: ;
			endcase
		end else if (cmd.year_step) begin
			days_q   <= days_q - esc_pkg::DAYS_W'(ylen);
			year_q   <= year_q + 1'b1;
			mod4_q   <= mod4_q + 1'b1;
			mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 1'b1;
			mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 1'b1;
		end else if (cmd.month_step) begin
			days_q  <= days_q - esc_pkg::DAYS_W'(mlen);
			month_q <= month_q + 1'b1;
		end

		if (cmd.out_load) begin
			sec_of_minute <= sec_q;
			min_of_hour   <= min_q;
			hour_of_day   <= hour_q;
			day_of_month  <= 5'(days_q[4:0] + 5'd1);
			month_of_year <= month_q + 4'd1;
			calendar_year <= year_q;
		end
	end

endmodule

### hw/rtl/esc_controller.sv
// ----------------------------------------------------------------------------
// esc_controller
// Sequencer for the three divisions, the year loop and the month loop, and
// the handshake state of both channels.
// ----------------------------------------------------------------------------
module esc_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  esc_pkg::status_t status,
	output esc_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV    = 3'd1;
	localparam logic [2:0] ST_DIVEND = 3'd2;
	localparam logic [2:0] ST_YEAR   = 3'd3;
	localparam logic [2:0] ST_MONTH  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]                state_q;
	logic [2:0]                state_d;
	logic [1:0]                phase_q;
	logic [esc_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      out_free;
	logic                      cnt_last;

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign cnt_last  = cnt_q == esc_pkg::CNT_W'(esc_pkg::DIGITS - 1);

	always_comb begin
		cmd            = '0;
		cmd.div_phase  = phase_q;
		state_d        = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_last) begin
					state_d = ST_DIVEND;
				end
			end
			ST_DIVEND: begin
				cmd.div_end = 1'b1;
				state_d     = (phase_q == esc_pkg::PH_HOUR) ? ST_YEAR : ST_DIV;
			end
			ST_YEAR: begin
				if (status.year_fits) begin
					state_d = ST_MONTH;
				end else begin
					cmd.year_step = 1'b1;
				end
			end
			ST_MONTH: begin
				if (status.month_fits) begin
					state_d = ST_DONE;
				end else begin
					cmd.month_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= esc_pkg::PH_SEC;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				phase_q <= esc_pkg::PH_SEC;
			end else if (cmd.div_end) begin
				phase_q <= phase_q + 2'd1;
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken but block not busy next cycle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result valid raised outside the done state");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (phase_q != 2'd3))
		else $error("division phase out of range");

	a_year_to_month: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR) && status.year_fits |=> (state_q == ST_MONTH))
		else $error("year loop did not hand over to month loop");

endmodule

### hw/rtl/epoch_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Converts a count of seconds since 1970-01-01 00:00:00 to the Gregorian
// date and time of day.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, epoch_seconds) takes one item at a
// time; in_stall stays high from acceptance until the result is handed to
// the output register. The output channel (out_valid, out_stall and the six
// result fields) holds one result until it is taken.
// Each of the three divisions by 60, 60 and 24 takes twelve bits of the count
// per cycle and ends with a step that stores its remainder. Then the year
// loop takes off one whole year since 1970 per step until the remaining days
// fit in the current year, the month loop does the same for the months of the
// final year, and the result is loaded into the output register. The unit can
// take the next item in the cycle after the result is loaded.
// A new item may be accepted while the previous result still waits on a
// stalled output. If the receiver stalls, the finished item waits in the
// unit and the input remains stalled until the output register frees.
// Reset clears the sequencer and the output valid flag; no item is held.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [esc_pkg::SECONDS_BITS-1:0] epoch_seconds,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [5:0]                       sec_of_minute,
	output logic [5:0]                       min_of_hour,
	output logic [4:0]                       hour_of_day,
	output logic [4:0]                       day_of_month,
	output logic [3:0]                       month_of_year,
	output logic [12:0]                      calendar_year
);

	esc_pkg::cmd_t    cmd;
	esc_pkg::status_t status;

	esc_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	esc_datapath u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.status        (status),
		.epoch_seconds (epoch_seconds),
		.sec_of_minute (sec_of_minute),
		.min_of_hour   (min_of_hour),
		.hour_of_day   (hour_of_day),
		.day_of_month  (day_of_month),
		.month_of_year (month_of_year),
		.calendar_year (calendar_year)
	);

endmodule

### verif/epoch_seconds_to_calendar_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit_tb
// Checks the conversion of seconds since 1970-01-01 00:00:00 to the Gregorian
// date and time of day. Corner cases around minute, day, month, year and
// leap-century boundaries come first, then random items. Most of them fall
// before 2106, and a few span the full input width. Every accepted item is
// converted by a behavioral model in the bench, and each result is compared
// field by field. Both channels idle at random in three profiles.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit_tb;

	localparam int SB             = esc_pkg::SECONDS_BITS;
	localparam int FIRST_YEAR     = 1970;
	localparam int RANDOM_ITEMS   = 250;
	localparam int WATCHDOG_LIMIT = 25000;
	localparam int SETTLE_CYCLES  = 50;

	typedef struct {
		logic [SB-1:0] seconds;
		bit            drain_first;
	} request_t;

	typedef struct {
		logic [5:0]  sec_of_minute;
		logic [5:0]  min_of_hour;
		logic [4:0]  hour_of_day;
		logic [4:0]  day_of_month;
		logic [3:0]  month_of_year;
		logic [12:0] calendar_year;
	} calendar_t;

	logic          clk           = 1'b0;
	logic          arst_n        = 1'b0;
	logic          in_valid      = 1'b0;
	logic          in_stall;
	logic [SB-1:0] epoch_seconds = '0;
	logic          out_valid;
	logic          out_stall     = 1'b0;
	logic [5:0]    sec_of_minute;
	logic [5:0]    min_of_hour;
	logic [4:0]    hour_of_day;
	logic [4:0]    day_of_month;
	logic [3:0]    month_of_year;
	logic [12:0]   calendar_year;

	request_t  seconds_queue[$];
	calendar_t dates_due[$];
	logic      in_taken    = 1'b0;
	int        items_in    = 0;
	int        results_out = 0;
	int        mismatches  = 0;
	int        idle_cycles = 0;
	int        total_items = 0;
	int        corner_items = 0;
	int        send_idle_pct;
	int        recv_idle_pct;

	epoch_seconds_to_calendar_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.epoch_seconds (epoch_seconds),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sec_of_minute (sec_of_minute),
		.min_of_hour   (min_of_hour),
		.hour_of_day   (hour_of_day),
		.day_of_month  (day_of_month),
		.month_of_year (month_of_year),
		.calendar_year (calendar_year)
	);

	always #5 clk = ~clk;

	assign send_idle_pct = (items_in < total_items / 3) ? 13 :
		(items_in < 2 * total_items / 3) ? 60 : 0;
	assign recv_idle_pct = (items_in < total_items / 3) ? 60 :
		(items_in < 2 * total_items / 3) ? 13 : 0;

	function automatic bit leap_year(input int unsigned year);
		return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
	endfunction

	function automatic calendar_t convert_epoch(input logic [SB-1:0] seconds);
		calendar_t     date;
		longint unsigned total;
		longint unsigned mins;
		longint unsigned hours;
		longint unsigned days;
		longint unsigned span;
		int unsigned   year;
		int unsigned   month;
		int unsigned   month_len[12];
		month_len = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		total = seconds;
		mins  = total / 60;
		hours = mins / 60;
		days  = hours / 24;
		date.sec_of_minute = 6'(total % 60);
		date.min_of_hour   = 6'(mins % 60);
		date.hour_of_day   = 5'(hours % 24);
		year = FIRST_YEAR;
		span = leap_year(year) ? 366 : 365;
		while (days >= span) begin
			days -= span;
			year++;
			span = leap_year(year) ? 366 : 365;
		end
		month = 0;
		while (month < 12) begin
			span = month_len[month];
			if (month == 1 && leap_year(year))
				span = 29;
			if (days < span)
				break;
			days -= span;
			month++;
		end
		date.day_of_month  = 5'(days + 1);
		date.month_of_year = 4'(month + 1);
		date.calendar_year = 13'(year);
		return date;
	endfunction

	task automatic queue_item(input longint unsigned seconds, input bit drain_first);
		request_t req;
		req.seconds     = SB'(seconds);
		req.drain_first = drain_first;
		seconds_queue.push_back(req);
	endtask

	task automatic check_field(input string label, input int unsigned want,
			input int unsigned got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (seconds_queue.size() != 0 &&
					!(seconds_queue[0].drain_first && dates_due.size() != 0) &&
					$urandom_range(99) >= send_idle_pct) begin
				in_valid      <= 1'b1;
				epoch_seconds <= seconds_queue[0].seconds;
				void'(seconds_queue.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		calendar_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_out++;
			if (dates_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
					$time, calendar_year, month_of_year, day_of_month,
					hour_of_day, min_of_hour, sec_of_minute);
				mismatches++;
			end else begin
				want = dates_due.pop_front();
				check_field("sec_of_minute", want.sec_of_minute, sec_of_minute);
				check_field("min_of_hour", want.min_of_hour, min_of_hour);
				check_field("hour_of_day", want.hour_of_day, hour_of_day);
				check_field("day_of_month", want.day_of_month, day_of_month);
				check_field("month_of_year", want.month_of_year, month_of_year);
				check_field("calendar_year", want.calendar_year, calendar_year);
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			dates_due.push_back(convert_epoch(epoch_seconds));
			items_in++;
		end
		in_taken    <= arst_n && in_valid && !in_stall;
		idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
			0 : idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("** epoch_seconds_to_calendar_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		longint unsigned day;
		int unsigned     pick;
		// Minute, hour and day rollovers.
		queue_item(0, 1'b0);
		queue_item(59, 1'b0);
		queue_item(60, 1'b0);
		queue_item(3599, 1'b0);
		queue_item(3600, 1'b0);
		queue_item(86399, 1'b0);
		queue_item(86400, 1'b0);
		// End of January and the first year boundary.
		queue_item(2678399, 1'b0);
		queue_item(2678400, 1'b0);
		queue_item(31535999, 1'b0);
		queue_item(31536000, 1'b0);
		// The leap day of 1972 and the end of that leap year.
		queue_item(68169599, 1'b0);
		queue_item(68169600, 1'b0);
		queue_item(68256000, 1'b0);
		queue_item(94694399, 1'b0);
		// 2000 is a leap year; 2100 is not.
		queue_item(946684799, 1'b0);
		queue_item(951782400, 1'b0);
		queue_item(4107542399, 1'b0);
		queue_item(4107542400, 1'b1);
		queue_item(64'hFFFF_FFFF, 1'b0);
		queue_item(64'h5_5555_5555, 1'b0);
		queue_item(64'hA_AAAA_AAAA, 1'b0);
		queue_item((64'd1 << SB) - 1, 1'b1);
		corner_items = seconds_queue.size();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				queue_item({32'd0, $urandom()}, (i % 40) == 0);
			end else if (pick < 80) begin
				queue_item({28'd0, 4'($urandom_range(15)), $urandom()}, (i % 40) == 0);
			end else begin
				day = $urandom_range(49000);
				queue_item(day * 86400 + ($urandom_range(1) ? 86399 : 0), (i % 40) == 0);
			end
		end
		total_items = seconds_queue.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (seconds_queue.size() != 0 || in_valid || dates_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Converted %0d items: %0d corner cases and %0d random, under three idle profiles.",
			items_in, corner_items, items_in - corner_items);
		$display("Checked %0d results with %0d mismatches.", results_out, mismatches);
		if (mismatches == 0 && dates_due.size() == 0) begin
			$display("** epoch_seconds_to_calendar_unit: PASSED **");
		end else begin
			$display("** epoch_seconds_to_calendar_unit: FAILED **");
		end
		$finish;
	end

endmodule
